### hdl/mqgf_pkg.sv
package mqgf_pkg;

    // Default sizes
    localparam int NUM_QUEUES_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Group size and the most groups one tick may form
    localparam int GROUP_SIZE = 4;
    localparam int MAX_GROUPS = 16;
    localparam int CNT_W      = 5;

    // Operation codes
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_GROUP  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RM_Q,
        ST_RM_RD,
        ST_RM_CK,
        ST_APPEND,
        ST_ANSWER,
        ST_TK_Q,
        ST_TK_RD,
        ST_TK_CK,
        ST_TK_EMIT,
        ST_TK_MV_RD,
        ST_TK_MV_CK
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input transaction
        logic scan_init;  // queue index, group count and found flag to zero
        logic q_inc;      // next queue
        logic r_clr;      // read and write pointers to zero
        logic rd;         // read entry r of queue q
        logic rm_check;   // compare read word, keep or drop it
        logic fill_rm;    // fill of queue q takes write pointer, next queue
        logic append;     // append the id to the target queue if room
        logic answer;     // present the enqueue or cancel answer
        logic grp_cap;    // capture one group member
        logic grp_emit;   // present the group, pointer to four
        logic mv_write;   // move the read word four places down
        logic fill_sub;   // fill of queue q less four, next queue
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       id_zero;
        logic       q_end;
        logic       r_at_fill;
        logic       grp_ready;
        logic       cnt_full;
        logic       r_is_last_member;
    } t_status;

endpackage

### hdl/multi_queue_group_former_top.sv
// Group former over NUM_QUEUES FIFOs of 32-bit member ids. A transaction is
// taken when start is high and busy low; every result appears for exactly one
// cycle with o_valid high and cannot be held off, so the receiver must take
// each one as it comes. Enqueue of a non-zero id and cancel walk every stored
// id through the member store, which has one write port and one registered
// read port. A tick scans the queues in order and, in each queue that holds a
// full group, reads the group and moves the remaining ids down; groups of one
// tick come out spaced by that compaction. After reset the block is ready at
// once: fill counts clear while reset is held.
module multi_queue_group_former_top import mqgf_pkg::*; #(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_member_id,
    input  logic [3:0]  i_queue_index,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic        o_ok,
    output logic [3:0]  o_group_queue,
    output logic [31:0] o_member_a,
    output logic [31:0] o_member_b,
    output logic [31:0] o_member_c,
    output logic [31:0] o_member_d,
    output logic        o_last
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    mqgf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Store, counts and result registers
    mqgf_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_op),
        .i_member_id   (i_member_id),
        .i_queue_index (i_queue_index),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_ok          (o_ok),
        .o_group_queue (o_group_queue),
        .o_member_a    (o_member_a),
        .o_member_b    (o_member_b),
        .o_member_c    (o_member_c),
        .o_member_d    (o_member_d),
        .o_last        (o_last)
    );

endmodule

### hdl/mqgf_ctrl.sv
module mqgf_ctrl import mqgf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_ENQ:    n_state = i_status.id_zero ? ST_ANSWER : ST_RM_Q;
                    OP_CANCEL: n_state = ST_RM_Q;
                    OP_TICK:   n_state = ST_TK_Q;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_RM_Q: begin
                if (i_status.q_end) begin
                    n_state = (i_status.op == OP_ENQ) ? ST_APPEND : ST_ANSWER;
                end else begin
                    n_state = ST_RM_RD;
                end
            end
            ST_RM_RD: n_state = i_status.r_at_fill ? ST_RM_Q : ST_RM_CK;
            ST_RM_CK: n_state = ST_RM_RD;
            ST_APPEND: n_state = ST_ANSWER;
            ST_ANSWER: n_state = ST_IDLE;
            ST_TK_Q: begin
                if (i_status.q_end || i_status.cnt_full) begin
                    n_state = ST_IDLE;
                end else if (i_status.grp_ready) begin
                    n_state = ST_TK_RD;
                end
            end
            ST_TK_RD: n_state = ST_TK_CK;
            ST_TK_CK: n_state = i_status.r_is_last_member ? ST_TK_EMIT : ST_TK_RD;
            ST_TK_EMIT: n_state = ST_TK_MV_RD;
            ST_TK_MV_RD: n_state = i_status.r_at_fill ? ST_TK_Q : ST_TK_MV_CK;
            ST_TK_MV_CK: n_state = ST_TK_MV_RD;
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: o_cmd.load = start;
            ST_DISPATCH: o_cmd.scan_init = 1'b1;
            ST_RM_Q: o_cmd.r_clr = !i_status.q_end;
            ST_RM_RD: begin
                o_cmd.rd      = !i_status.r_at_fill;
                o_cmd.fill_rm = i_status.r_at_fill;
            end
            ST_RM_CK: o_cmd.rm_check = 1'b1;
            ST_APPEND: o_cmd.append = 1'b1;
            ST_ANSWER: o_cmd.answer = 1'b1;
            ST_TK_Q: begin
                if (!i_status.q_end && !i_status.cnt_full) begin
                    o_cmd.r_clr = i_status.grp_ready;
                    o_cmd.q_inc = !i_status.grp_ready;
                end
            end
            ST_TK_RD: o_cmd.rd = 1'b1;
            ST_TK_CK: o_cmd.grp_cap = 1'b1;
            ST_TK_EMIT: o_cmd.grp_emit = 1'b1;
            ST_TK_MV_RD: begin
                o_cmd.rd       = !i_status.r_at_fill;
                o_cmd.fill_sub = i_status.r_at_fill;
            end
            ST_TK_MV_CK: o_cmd.mv_write = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // Busy while working and while held in reset
    assign busy = (r_state != ST_IDLE) || !i_rst_n;

endmodule

### hdl/mqgf_dp.sv
module mqgf_dp import mqgf_pkg::*; #(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_member_id,
    input  logic [3:0]  i_queue_index,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic        o_ok,
    output logic [3:0]  o_group_queue,
    output logic [31:0] o_member_a,
    output logic [31:0] o_member_b,
    output logic [31:0] o_member_c,
    output logic [31:0] o_member_d,
    output logic        o_last
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = QW + DW;
    localparam int XW = (QW > 4) ? QW : 4;

    // Member store, one row of QUEUE_DEPTH words per queue
    logic [31:0] r_mem [0:(2**AW)-1];
    logic [31:0] r_rdata;

    logic [FW-1:0] r_fill [0:NUM_QUEUES-1];

    logic [1:0]       r_op;
    logic [31:0]      r_id;
    logic [3:0]       r_qi;
    logic [QW:0]      r_q;
    logic [FW-1:0]    r_r;
    logic [FW-1:0]    r_w;
    logic             r_found;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_grp [0:GROUP_SIZE-1];

    logic [QW-1:0] q_idx;
    logic [XW-1:0] qi_ext;
    logic [QW-1:0] qi_idx;
    logic          qi_valid;
    logic          qi_room;
    logic [FW-1:0] fill_q;
    logic          ready_above;
    logic [FW-1:0] mv_ptr;

    assign q_idx    = r_q[QW-1:0];
    assign qi_ext   = XW'(r_qi);
    assign qi_idx   = qi_ext[QW-1:0];
    assign qi_valid = (32'(r_qi) < NUM_QUEUES);
    assign fill_q   = r_fill[q_idx];
    assign qi_room  = qi_valid && (32'(r_fill[qi_idx]) < QUEUE_DEPTH);
    assign mv_ptr   = r_r - FW'(GROUP_SIZE);

    // Any later queue still holding a full group
    always_comb begin
        ready_above = 1'b0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if ((i > 32'(r_q)) && (32'(r_fill[i]) >= GROUP_SIZE)) ready_above = 1'b1;
        end
    end

    // Status
    always_comb begin
        o_status.op               = r_op;
        o_status.id_zero          = (r_id == 32'd0);
        o_status.q_end            = (32'(r_q) >= NUM_QUEUES);
        o_status.r_at_fill        = (r_r == fill_q);
        o_status.grp_ready        = (32'(fill_q) >= GROUP_SIZE);
        o_status.cnt_full         = (32'(r_cnt) >= MAX_GROUPS);
        o_status.r_is_last_member = (32'(r_r) == GROUP_SIZE - 1);
    end

    // Member store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= r_mem[{q_idx, r_r[DW-1:0]}];
        if (i_cmd.rm_check && (r_rdata != r_id)) begin
            r_mem[{q_idx, r_w[DW-1:0]}] <= r_rdata;
        end else if (i_cmd.mv_write) begin
            r_mem[{q_idx, mv_ptr[DW-1:0]}] <= r_rdata;
        end else if (i_cmd.append && qi_room) begin
            r_mem[{qi_idx, r_fill[qi_idx][DW-1:0]}] <= r_id;
        end
    end

    // Fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) r_fill[i] <= '0;
        end else if (i_cmd.fill_rm) begin
            r_fill[q_idx] <= r_w;
        end else if (i_cmd.fill_sub) begin
            r_fill[q_idx] <= fill_q - FW'(GROUP_SIZE);
        end else if (i_cmd.append && qi_room) begin
            r_fill[qi_idx] <= r_fill[qi_idx] + 1'b1;
        end
    end

    // Transaction, pointers and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_member_id;
            r_qi <= i_queue_index;
        end
        if (i_cmd.scan_init) begin
            r_q     <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.q_inc || i_cmd.fill_rm || i_cmd.fill_sub) r_q <= r_q + 1'b1;
        if (i_cmd.r_clr) begin
            r_r <= '0;
            r_w <= '0;
        end
        if (i_cmd.rm_check) begin
            r_r <= r_r + 1'b1;
            if (r_rdata == r_id) begin
                r_found <= 1'b1;
            end else begin
                r_w <= r_w + 1'b1;
            end
        end
        if (i_cmd.grp_cap) begin
            r_grp[r_r[1:0]] <= r_rdata;
            r_r <= r_r + 1'b1;
        end
        if (i_cmd.grp_emit) begin
            r_r   <= FW'(GROUP_SIZE);
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mv_write) r_r <= r_r + 1'b1;
        if (i_cmd.append) r_found <= qi_room;
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.answer || i_cmd.grp_emit;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.answer) begin
            o_kind        <= (r_op == OP_ENQ) ? KIND_ENQ : KIND_CANCEL;
            o_ok          <= r_found && !(r_id == 32'd0);
            o_group_queue <= '0;
            o_member_a    <= '0;
            o_member_b    <= '0;
            o_member_c    <= '0;
            o_member_d    <= '0;
            o_last        <= 1'b1;
        end else if (i_cmd.grp_emit) begin
            o_kind        <= KIND_GROUP;
            o_ok          <= 1'b1;
            o_group_queue <= 4'(r_q);
            o_member_a    <= r_grp[0];
            o_member_b    <= r_grp[1];
            o_member_c    <= r_grp[2];
            o_member_d    <= r_grp[3];
            o_last        <= (32'(r_cnt) == MAX_GROUPS - 1) || !ready_above;
        end
    end

endmodule
